// ===== src/cpf_pkg.sv =====
// Shared types, constants and the control program of the calibrated position filter.
package cpf_pkg;

  // Full scale of the percent value in units of 1/65536 percent.
  localparam logic [22:0] PCT_SCALE = 23'd6553600;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_RAW_FINE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RAW_COARSE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEP_COUNT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REVERSE    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA      = 3'd4;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] PC_CHECK = 4'd1;
  localparam logic [PC_W-1:0] PC_TRIV  = 4'd2;
  localparam logic [PC_W-1:0] PC_DIV   = 4'd3;
  localparam logic [PC_W-1:0] PC_REV   = 4'd4;
  localparam logic [PC_W-1:0] PC_MPCT  = 4'd5;
  localparam logic [PC_W-1:0] PC_TGT   = 4'd6;
  localparam logic [PC_W-1:0] PC_STEP  = 4'd7;
  localparam logic [PC_W-1:0] PC_EMA   = 4'd8;
  localparam logic [PC_W-1:0] PC_OUT   = 4'd9;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_TRIV,
    OP_DIV,
    OP_REV,
    OP_MUL_PCT,
    OP_TGT,
    OP_STEP,
    OP_EMA,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_IN,
    COND_ERR,
    COND_TRIV,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            last;
  } ctrl_t;

  typedef struct packed {
    logic err;
    logic triv;
    logic div_more;
    logic out_busy;
  } flags_t;

  typedef struct packed {
    logic signed [15:0] raw_fine;
    logic signed [15:0] raw_coarse;
    logic [7:0]         step_count;
    logic               reverse;
    logic [15:0]        alpha;
  } cfg_t;

  // Control store: one word per step. A word jumps to its target when its
  // condition holds, otherwise it falls through (or wraps to idle if last).
  function automatic ctrl_t prog_word(logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_NOP, cond: COND_NEVER, target: PC_IDLE, last: 1'b1};
    unique case (pc)
      PC_IDLE:  w = '{op: OP_LOAD,    cond: COND_NO_IN,    target: PC_IDLE, last: 1'b0};
      PC_CHECK: w = '{op: OP_NOP,     cond: COND_ERR,      target: PC_OUT,  last: 1'b0};
      PC_TRIV:  w = '{op: OP_TRIV,    cond: COND_TRIV,     target: PC_REV,  last: 1'b0};
      PC_DIV:   w = '{op: OP_DIV,     cond: COND_DIV_MORE, target: PC_DIV,  last: 1'b0};
      PC_REV:   w = '{op: OP_REV,     cond: COND_NEVER,    target: PC_IDLE, last: 1'b0};
      PC_MPCT:  w = '{op: OP_MUL_PCT, cond: COND_NEVER,    target: PC_IDLE, last: 1'b0};
      PC_TGT:   w = '{op: OP_TGT,     cond: COND_NEVER,    target: PC_IDLE, last: 1'b0};
      PC_STEP:  w = '{op: OP_STEP,    cond: COND_NEVER,    target: PC_IDLE, last: 1'b0};
      PC_EMA:   w = '{op: OP_EMA,     cond: COND_NEVER,    target: PC_IDLE, last: 1'b0};
      PC_OUT:   w = '{op: OP_OUT,     cond: COND_OUT_BUSY, target: PC_OUT,  last: 1'b1};
      default:  w = '{op: OP_NOP,     cond: COND_NEVER,    target: PC_IDLE, last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

// ===== src/cpf_seq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module cpf_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  cpf_pkg::flags_t     flags,
  output cpf_pkg::ctrl_t      ctrl,
  output logic                in_stall
);

  logic [cpf_pkg::PC_W-1:0] pc_r;
  logic [cpf_pkg::PC_W-1:0] pc_nxt;
  logic                     take;

  assign ctrl     = cpf_pkg::prog_word(pc_r);
  assign in_stall = (pc_r != cpf_pkg::PC_IDLE);

  always_comb begin
    case (ctrl.cond)
      cpf_pkg::COND_NO_IN:    take = !in_valid;
      cpf_pkg::COND_ERR:      take = flags.err;
      cpf_pkg::COND_TRIV:     take = flags.triv;
      cpf_pkg::COND_DIV_MORE: take = flags.div_more;
      cpf_pkg::COND_OUT_BUSY: take = flags.out_busy;
      default:                take = 1'b0;
    endcase
    if (take) begin
      pc_nxt = ctrl.target;
    end else if (ctrl.last) begin
      pc_nxt = cpf_pkg::PC_IDLE;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= cpf_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== src/cpf_dp.sv =====
// Datapath: divider, shared multiplier, moving average and output register.
module cpf_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cpf_pkg::ctrl_t     ctrl,
  input  cpf_pkg::cfg_t      cfg,
  input  logic               calib_wr,
  input  logic               in_valid,
  input  logic signed [15:0] in_reading,
  input  logic               out_stall,
  output cpf_pkg::flags_t    flags,
  output logic               out_valid,
  output logic [14:0]        out_filtered_percent,
  output logic [7:0]         out_step_index,
  output logic signed [15:0] out_raw_echo,
  output logic               out_calibration_error
);

  localparam int P_W    = FRAC_BITS + 1;
  localparam int MA_W   = (P_W > 24) ? P_W : 24;
  localparam int PROD_W = MA_W + 23;
  localparam int CNT_W  = $clog2(FRAC_BITS);
  localparam logic [P_W-1:0]    ONE  = P_W'(1) << FRAC_BITS;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [PROD_W-1:0] RND16 = PROD_W'(32768);

  logic [15:0]        last_raw_r, last_raw_nxt;
  logic signed [16:0] num_r, num_nxt;
  logic [15:0]        den_r, den_nxt;
  logic               err_r, err_nxt;
  logic [15:0]        rem_r, rem_nxt;
  logic [P_W-1:0]     p_r, p_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [23:0]        target_r, target_nxt;
  logic               dir_r, dir_nxt;
  logic [23:0]        fv_r, fv_nxt;
  logic               seeded_r, seeded_nxt;
  logic [7:0]         cur_step_r, cur_step_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [14:0]        out_fp_r, out_fp_nxt;
  logic [7:0]         out_step_r, out_step_nxt;
  logic [15:0]        out_raw_r, out_raw_nxt;
  logic               out_err_r, out_err_nxt;

  logic signed [16:0] num_raw, den_raw;
  logic [16:0]        shifted;
  logic               sub_ok;
  logic               num_le0, num_ge;
  logic [MA_W-1:0]    mul_a;
  logic [22:0]        mul_b;
  logic [PROD_W-1:0]  rnd_sum, rnd_shift, ema_sum;
  logic [23:0]        diff, m;
  logic [8:0]         st;
  logic [24:0]        fp_sum;
  logic               busy;

  assign num_le0  = num_r[16] || (num_r == 17'sd0);
  assign num_ge   = !num_r[16] && (num_r[15:0] >= den_r);
  assign busy     = out_valid_r && out_stall;

  assign flags.err      = err_r;
  assign flags.triv     = num_le0 || num_ge;
  assign flags.div_more = (cnt_r != CNT_W'(FRAC_BITS - 1));
  assign flags.out_busy = busy;

  always_comb begin
    num_raw   = 17'({in_reading[15], in_reading} - {cfg.raw_fine[15], cfg.raw_fine});
    den_raw   = 17'({cfg.raw_coarse[15], cfg.raw_coarse} - {cfg.raw_fine[15], cfg.raw_fine});
    shifted   = {rem_r, 1'b0};
    sub_ok    = (shifted >= {1'b0, den_r});
    diff      = (target_r >= fv_r) ? (target_r - fv_r) : (fv_r - target_r);
    rnd_sum   = prod_r + HALF;
    rnd_shift = rnd_sum >> FRAC_BITS;
    ema_sum   = prod_r + RND16;
    m         = ema_sum[39:16];
    st        = rnd_shift[8:0] + 9'd1;
    fp_sum    = {1'b0, fv_r} + 25'd128;

    mul_a = MA_W'(p_r);
    mul_b = cpf_pkg::PCT_SCALE;

    last_raw_nxt  = last_raw_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    err_nxt       = err_r;
    rem_nxt       = rem_r;
    p_nxt         = p_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    target_nxt    = target_r;
    dir_nxt       = dir_r;
    fv_nxt        = fv_r;
    seeded_nxt    = seeded_r;
    cur_step_nxt  = cur_step_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_fp_nxt    = out_fp_r;
    out_step_nxt  = out_step_r;
    out_raw_nxt   = out_raw_r;
    out_err_nxt   = out_err_r;

    case (ctrl.op)
      cpf_pkg::OP_LOAD: begin
        if (in_valid) begin
          last_raw_nxt = in_reading;
          err_nxt      = (cfg.raw_fine == cfg.raw_coarse);
          if (den_raw[16]) begin
            num_nxt = -num_raw;
            den_nxt = 16'(-den_raw);
          end else begin
            num_nxt = num_raw;
            den_nxt = den_raw[15:0];
          end
        end
      end
      cpf_pkg::OP_TRIV: begin
        cnt_nxt = '0;
        rem_nxt = num_r[15:0];
        if (num_le0) begin
          p_nxt = '0;
        end else if (num_ge) begin
          p_nxt = ONE;
        end else begin
          p_nxt = '0;
        end
      end
      cpf_pkg::OP_DIV: begin
        rem_nxt = sub_ok ? 16'(shifted - {1'b0, den_r}) : shifted[15:0];
        p_nxt   = {p_r[P_W-2:0], sub_ok};
        cnt_nxt = cnt_r + 1'b1;
      end
      cpf_pkg::OP_REV: begin
        if (cfg.reverse) begin
          p_nxt = ONE - p_r;
        end
      end
      cpf_pkg::OP_MUL_PCT: begin
        prod_nxt = PROD_W'(mul_a * mul_b);
      end
      cpf_pkg::OP_TGT: begin
        target_nxt = rnd_shift[23:0];
        mul_b      = 23'(cfg.step_count - 8'd1);
        prod_nxt   = PROD_W'(mul_a * mul_b);
      end
      cpf_pkg::OP_STEP: begin
        cur_step_nxt = (st > {1'b0, cfg.step_count}) ? cfg.step_count : st[7:0];
        dir_nxt      = (target_r >= fv_r);
        mul_a        = MA_W'(diff);
        mul_b        = 23'(cfg.alpha);
        prod_nxt     = PROD_W'(mul_a * mul_b);
      end
      cpf_pkg::OP_EMA: begin
        seeded_nxt = 1'b1;
        if (!seeded_r) begin
          fv_nxt = target_r;
        end else if (dir_r) begin
          fv_nxt = fv_r + m;
        end else begin
          fv_nxt = fv_r - m;
        end
      end
      cpf_pkg::OP_OUT: begin
        if (!busy) begin
          out_valid_nxt = 1'b1;
          out_fp_nxt    = fp_sum[22:8];
          out_step_nxt  = cur_step_r;
          out_raw_nxt   = last_raw_r;
          out_err_nxt   = err_r;
        end
      end
      default: begin
      end
    endcase

    if (calib_wr) begin
      seeded_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r  <= '0;
      fv_r        <= '0;
      seeded_r    <= 1'b0;
      cur_step_r  <= 8'd1;
      out_valid_r <= 1'b0;
    end else begin
      last_raw_r  <= last_raw_nxt;
      fv_r        <= fv_nxt;
      seeded_r    <= seeded_nxt;
      cur_step_r  <= cur_step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    err_r     <= err_nxt;
    rem_r     <= rem_nxt;
    p_r       <= p_nxt;
    cnt_r     <= cnt_nxt;
    prod_r    <= prod_nxt;
    target_r  <= target_nxt;
    dir_r     <= dir_nxt;
    out_fp_r  <= out_fp_nxt;
    out_step_r <= out_step_nxt;
    out_raw_r <= out_raw_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_filtered_percent  = out_fp_r;
  assign out_step_index        = out_step_r;
  assign out_raw_echo          = out_raw_r;
  assign out_calibration_error = out_err_r;

endmodule

// ===== src/calibrated_position_filter.sv =====
// Top level of the calibrated position filter: configuration registers and unit wiring.
//
// The block turns one signed ADC reading per input transaction into one result
// transaction: the smoothed position in 1/256 percent, a rounded step index, an
// echo of the reading and a flag that is set when both calibration points match.
// The input channel takes a transaction only while the sequencer sits in its idle
// step, so in_stall is high from the cycle after acceptance until the result has
// been loaded into the output register. A reading strictly between the two
// calibration points passes through the restoring divider, which retires one
// quotient bit per cycle; readings at or beyond a point skip the divider, and a
// calibration error goes straight to the output step. The next item can be
// accepted in the cycle after the result register is loaded, so the block takes
// no new reading before it is through with the last one.
// The output register holds a result while out_stall is high; the sequencer then
// waits in its output step and does not accept new input until it can unload.
// The configuration channel is always ready and should be written only while the
// block is idle. Writing a calibration register, the step count or the direction
// reseeds the moving average with the next sample; writing alpha does not.
// Synchronous reset restores the default calibration, clears the average and
// sets the step to one; no clearing pass is needed.
module calibrated_position_filter #(
  parameter int MIN_STEPS = 1,
  parameter int MAX_STEPS = 255,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [15:0]              in_reading,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [14:0]                     out_filtered_percent,
  output logic [7:0]                      out_step_index,
  output logic signed [15:0]              out_raw_echo,
  output logic                            out_calibration_error,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cpf_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_data
);

  cpf_pkg::cfg_t   cfg_r;
  cpf_pkg::cfg_t   cfg_nxt;
  logic            calib_wr;
  logic            cfg_wr;
  logic [7:0]      steps_in;
  cpf_pkg::ctrl_t  ctrl;
  cpf_pkg::flags_t flags;

  // Configuration is never back-pressured.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign steps_in  = cfg_data[7:0];

  // Every register except alpha counts as a calibration write and drops the seed.
  always_comb begin
    cfg_nxt  = cfg_r;
    calib_wr = 1'b0;
    if (cfg_wr) begin
      case (cfg_index)
        cpf_pkg::REG_RAW_FINE: begin
          cfg_nxt.raw_fine = cfg_data;
          calib_wr         = 1'b1;
        end
        cpf_pkg::REG_RAW_COARSE: begin
          cfg_nxt.raw_coarse = cfg_data;
          calib_wr           = 1'b1;
        end
        cpf_pkg::REG_STEP_COUNT: begin
          // The step count is saturated to the supported range as it is written.
          if (steps_in < 8'(MIN_STEPS)) begin
            cfg_nxt.step_count = 8'(MIN_STEPS);
          end else if (steps_in > 8'(MAX_STEPS)) begin
            cfg_nxt.step_count = 8'(MAX_STEPS);
          end else begin
            cfg_nxt.step_count = steps_in;
          end
          calib_wr = 1'b1;
        end
        cpf_pkg::REG_REVERSE: begin
          cfg_nxt.reverse = cfg_data[0];
          calib_wr        = 1'b1;
        end
        cpf_pkg::REG_ALPHA: begin
          cfg_nxt.alpha = cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.raw_fine   <= 16'sd0;
      cfg_r.raw_coarse <= 16'sd32767;
      cfg_r.step_count <= 8'd100;
      cfg_r.reverse    <= 1'b0;
      cfg_r.alpha      <= 16'd6554;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The sequencer walks the control store; the datapath executes each word.
  cpf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .flags    (flags),
    .ctrl     (ctrl),
    .in_stall (in_stall)
  );

  cpf_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .ctrl                  (ctrl),
    .cfg                   (cfg_r),
    .calib_wr              (calib_wr),
    .in_valid              (in_valid),
    .in_reading            (in_reading),
    .out_stall             (out_stall),
    .flags                 (flags),
    .out_valid             (out_valid),
    .out_filtered_percent  (out_filtered_percent),
    .out_step_index        (out_step_index),
    .out_raw_echo          (out_raw_echo),
    .out_calibration_error (out_calibration_error)
  );

endmodule

// ===== tb/cpf_checker.sv =====
// Scoreboard for the calibrated position filter: predicts each result and checks the output channel.
module cpf_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [15:0]            in_reading,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [14:0]                   out_filtered_percent,
  input  logic [7:0]                    out_step_index,
  input  logic signed [15:0]            out_raw_echo,
  input  logic                          out_calibration_error,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [cpf_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            checked,
  output int                            error_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC      = 16;
  localparam int ONE       = 1 << FRAC;
  localparam int HALF      = 1 << (FRAC - 1);
  localparam int STEP_MIN  = 1;
  localparam int STEP_MAX  = 255;
  localparam int PRINT_CAP = 30;

  typedef struct packed {
    logic [14:0]        percent;
    logic [7:0]         step;
    logic signed [15:0] echo;
    logic               err;
  } position_result_t;

  // Calibration as the block should currently hold it.
  logic signed [15:0] cal_fine;
  logic signed [15:0] cal_coarse;
  logic [7:0]         step_limit;
  logic               reverse_dir;
  logic [15:0]        alpha;

  // Filter state.
  logic               seeded;
  logic [23:0]        filt_value;
  logic [7:0]         cur_step;
  logic signed [15:0] last_reading;

  position_result_t expected_results[$];
  int mismatches = 0;
  int n_checked = 0;
  int n_err = 0;

  function automatic void reset_model();
    cal_fine     = 16'sd0;
    cal_coarse   = 16'sh7fff;
    step_limit   = 8'd100;
    reverse_dir  = 1'b0;
    alpha        = 16'd6554;
    seeded       = 1'b0;
    filt_value   = '0;
    cur_step     = 8'd1;
    last_reading = '0;
  endfunction

  function automatic void apply_register(input logic [cpf_pkg::REG_IDX_W-1:0] idx,
                                         input logic [15:0] value);
    case (idx)
      cpf_pkg::REG_RAW_FINE: begin
        cal_fine = value;
        seeded = 1'b0;
      end
      cpf_pkg::REG_RAW_COARSE: begin
        cal_coarse = value;
        seeded = 1'b0;
      end
      cpf_pkg::REG_STEP_COUNT: begin
        if (int'(value[7:0]) < STEP_MIN) step_limit = 8'(STEP_MIN);
        else if (int'(value[7:0]) > STEP_MAX) step_limit = 8'(STEP_MAX);
        else step_limit = value[7:0];
        seeded = 1'b0;
      end
      cpf_pkg::REG_REVERSE: begin
        reverse_dir = value[0];
        seeded = 1'b0;
      end
      cpf_pkg::REG_ALPHA: alpha = value;
      default: ;
    endcase
  endfunction

  // Advances the filter state by one reading and returns the result it should produce.
  function automatic position_result_t predict_position(input logic signed [15:0] rd);
    position_result_t r;
    logic signed [17:0] num;
    logic signed [17:0] den;
    logic [16:0]        pos;
    logic [23:0]        tgt;
    logic [63:0]        delta;
    logic [63:0]        st;
    last_reading = rd;
    r.err = (cal_fine == cal_coarse);
    if (!r.err) begin
      num = rd - cal_fine;
      den = cal_coarse - cal_fine;
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      if (num <= 0) pos = '0;
      else if (num >= den) pos = 17'(ONE);
      else pos = 17'((64'(num) << FRAC) / 64'(den));
      if (reverse_dir) pos = 17'(ONE) - pos;
      tgt = 24'((64'(pos) * 64'(cpf_pkg::PCT_SCALE) + 64'(HALF)) >> FRAC);
      if (!seeded) begin
        filt_value = tgt;
        seeded = 1'b1;
      end else if (tgt >= filt_value) begin
        delta = (64'(alpha) * 64'(tgt - filt_value) + 64'd32768) >> 16;
        filt_value = filt_value + delta[23:0];
      end else begin
        delta = (64'(alpha) * 64'(filt_value - tgt) + 64'd32768) >> 16;
        filt_value = filt_value - delta[23:0];
      end
      st = ((64'(pos) * 64'(step_limit - 8'd1) + 64'(HALF)) >> FRAC) + 64'd1;
      if (st > 64'(step_limit)) st = 64'(step_limit);
      cur_step = st[7:0];
    end
    r.percent = 15'((25'(filt_value) + 25'd128) >> 8);
    r.step    = cur_step;
    r.echo    = last_reading;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    position_result_t got;
    position_result_t want;
    if (!rst_n) begin
      reset_model();
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(predict_position(in_reading));
      if (out_valid && !out_stall) begin
        got = '{percent: out_filtered_percent, step: out_step_index,
                echo: out_raw_echo, err: out_calibration_error};
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result transaction with none outstanding (echo %0d)",
                                    got.echo));
        end else begin
          want = expected_results.pop_front();
          if (got.percent !== want.percent)
            report_mismatch($sformatf("filtered_percent for reading %0d: got %0d, expected %0d",
                                      want.echo, got.percent, want.percent));
          if (got.step !== want.step)
            report_mismatch($sformatf("step_index for reading %0d: got %0d, expected %0d",
                                      want.echo, got.step, want.step));
          if (got.echo !== want.echo)
            report_mismatch($sformatf("raw_echo: got %0d, expected %0d", got.echo, want.echo));
          if (got.err !== want.err)
            report_mismatch($sformatf("calibration_error for reading %0d: got %0b, expected %0b",
                                      want.echo, got.err, want.err));
          n_checked++;
          if (want.err) n_err++;
        end
      end
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
    end
    pending       <= expected_results.size();
    fail_count    <= mismatches;
    checked       <= n_checked;
    error_results <= n_err;
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the calibrated position filter: clock, reset, stimulus, idling and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W             = cpf_pkg::REG_IDX_W;
  localparam int CLK_HALF          = 5;
  localparam int RESET_CYCLES      = 5;
  // The receiver's long hold-off; the block fills up and stalls its input meanwhile.
  localparam int HOLD_CYCLES       = 400;
  // A correct run never goes this long without a transaction, even across the hold-off.
  localparam int WATCHDOG_LIMIT    = 5000;
  // Idle time at the end of the run; it covers any stray late result.
  localparam int SETTLE_CYCLES     = 40;
  localparam int SEGMENTS_PER_MODE = 16;
  localparam int HOLD_SEGMENT      = 3;
  // Register indexes past the last defined register; the block must ignore them.
  localparam logic [IDX_W-1:0] REG_SPARE_FIRST = 3'd5;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [15:0]    in_reading = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [14:0]           out_filtered_percent;
  logic [7:0]            out_step_index;
  logic signed [15:0]    out_raw_echo;
  logic                  out_calibration_error;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [15:0]           cfg_data = '0;

  int fail_count;
  int pending;
  int checked;
  int error_results;

  // Idle rates in percent. The sender's rate is used only by the stimulus process;
  // the receiver's rate and the hold-off request are updated with nonblocking
  // assignments so the receiver process sees them deterministically.
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  bit hold_request = 1'b0;

  // The calibration points last written, used to aim readings at the interior.
  logic signed [15:0] cur_fine = 16'sd0;
  logic signed [15:0] cur_coarse = 16'sh7fff;

  int readings_sent = 0;
  int reg_writes = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  always #CLK_HALF clk = ~clk;

  calibrated_position_filter dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_reading            (in_reading),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_filtered_percent  (out_filtered_percent),
    .out_step_index        (out_step_index),
    .out_raw_echo          (out_raw_echo),
    .out_calibration_error (out_calibration_error),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  cpf_checker chk (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_reading            (in_reading),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_filtered_percent  (out_filtered_percent),
    .out_step_index        (out_step_index),
    .out_raw_echo          (out_raw_echo),
    .out_calibration_error (out_calibration_error),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .fail_count            (fail_count),
    .pending               (pending),
    .checked               (checked),
    .error_results         (error_results)
  );

  // Writes one register and returns in the time step of the accepting edge with
  // cfg_valid still high, so that back-to-back writes never lower and raise it in
  // the same step. The caller lowers cfg_valid once the batch is done.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    if (idx == cpf_pkg::REG_RAW_FINE) cur_fine = value;
    else if (idx == cpf_pkg::REG_RAW_COARSE) cur_coarse = value;
  endtask

  // Offers one reading after a random number of idle cycles and returns in the
  // step of the accepting edge. in_valid stays high so a following transaction can
  // go out without a bubble; the idle loop drops it when a gap is chosen. The
  // idle decision never looks at in_stall, and the payload is held while stalled.
  task automatic send_reading(input logic signed [15:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_reading <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    readings_sent++;
  endtask

  // The sender pauses until every predicted result has been taken. The checker's
  // outstanding count is registered, so the sender waits for it to catch up first.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Most readings fall between the calibration points, ends included, which is
  // mostly where the divider does its real work; the rest land on or next to the
  // points, on the extremes of the 16-bit range, or anywhere at all.
  function automatic logic signed [15:0] pick_reading(input logic signed [15:0] a,
                                                       input logic signed [15:0] b);
    int lo;
    int hi;
    int sel;
    lo = (a < b) ? int'(a) : int'(b);
    hi = (a < b) ? int'(b) : int'(a);
    sel = $urandom_range(99);
    if (sel < 60) return 16'(lo + int'($urandom_range(hi - lo)));
    if (sel < 72) begin
      case ($urandom_range(5))
        0: return 16'(lo);
        1: return 16'(hi);
        2: return 16'(lo - 1);
        3: return 16'(hi + 1);
        4: return 16'(lo + 1);
        default: return 16'(hi - 1);
      endcase
    end
    if (sel < 80) begin
      case ($urandom_range(3))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return 16'sd0;
        default: return -16'sd1;
      endcase
    end
    return 16'($urandom);
  endfunction

  // Picks a new calibration while the block is idle. Each register is written with
  // good probability, with the extremes weighted up; the calibration points are
  // sometimes made equal to provoke the error path, and a spare index is written
  // now and then to show that the block ignores it.
  task automatic pick_settings();
    logic signed [15:0] f;
    logic signed [15:0] c;
    logic [7:0]         steps;
    logic [15:0]        a;
    int                 shape;
    shape = $urandom_range(11);
    f = 16'($urandom);
    c = 16'($urandom);
    case (shape)
      0: begin
        f = 16'sh8000;
        c = 16'sh7fff;
      end
      1: begin
        f = 16'sh7fff;
        c = 16'sh8000;
      end
      2: c = f;
      3: c = f + 16'($urandom_range(1, 4));
      4: c = f - 16'($urandom_range(1, 300));
      default: ;
    endcase
    if (shape < 5 || $urandom_range(3) != 0) begin
      write_reg(cpf_pkg::REG_RAW_FINE, f);
      write_reg(cpf_pkg::REG_RAW_COARSE, c);
    end
    if ($urandom_range(3) != 0) begin
      case ($urandom_range(7))
        0: steps = 8'd0;
        1: steps = 8'd1;
        2: steps = 8'd2;
        3: steps = 8'd255;
        default: steps = 8'($urandom_range(3, 254));
      endcase
      write_reg(cpf_pkg::REG_STEP_COUNT, {8'($urandom), steps});
    end
    if ($urandom_range(3) != 0) write_reg(cpf_pkg::REG_REVERSE, 16'($urandom));
    if ($urandom_range(3) != 0) begin
      case ($urandom_range(5))
        0: a = 16'd0;
        1: a = 16'hffff;
        2: a = 16'd1;
        default: a = 16'($urandom);
      endcase
      write_reg(cpf_pkg::REG_ALPHA, a);
    end
    if ($urandom_range(9) == 0)
      write_reg(REG_SPARE_FIRST + IDX_W'($urandom_range(2)), 16'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Receiver. Normally it stalls at random at the current rate; on request it
  // holds off for a long stretch while the sender keeps offering readings, so the
  // output register stays full and the block has to stall its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request <= 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < sink_idle_pct);
      end
    end
  end

  // Watchdog: ends the run if no transaction of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("calibrated_position_filter regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n_items;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Equal calibration points straight after reset: error flag with nothing
    // seeded, so the held percent must read as zero and the step as one.
    write_reg(cpf_pkg::REG_RAW_COARSE, 16'd0);
    cfg_valid <= 1'b0;
    send_reading(16'sd42);
    wait_for_results();

    // Default calibration: the points themselves, both range extremes and the interior.
    write_reg(cpf_pkg::REG_RAW_COARSE, 16'h7fff);
    cfg_valid <= 1'b0;
    send_reading(16'sd0);
    send_reading(16'sh7fff);
    send_reading(16'sh8000);
    send_reading(16'sd16384);
    send_reading(16'sd1);
    send_reading(16'sd32766);
    send_reading(-16'sd1);
    wait_for_results();

    // Widest span, reversed direction, most steps and the heaviest weight.
    write_reg(cpf_pkg::REG_RAW_FINE, 16'h8000);
    write_reg(cpf_pkg::REG_RAW_COARSE, 16'h7fff);
    write_reg(cpf_pkg::REG_STEP_COUNT, 16'd255);
    write_reg(cpf_pkg::REG_REVERSE, 16'd1);
    write_reg(cpf_pkg::REG_ALPHA, 16'hffff);
    cfg_valid <= 1'b0;
    send_reading(16'sh8000);
    send_reading(16'sh7fff);
    send_reading(16'sd0);
    send_reading(-16'sd1);
    send_reading(16'sd12345);
    wait_for_results();

    // A step count of zero saturates to one; with a zero weight the average
    // must stay at its seed.
    write_reg(cpf_pkg::REG_STEP_COUNT, 16'd0);
    write_reg(cpf_pkg::REG_ALPHA, 16'd0);
    cfg_valid <= 1'b0;
    send_reading(16'sd100);
    send_reading(-16'sd200);
    send_reading(16'sd30000);
    wait_for_results();

    // Coarse point below the fine one, two steps: the exact midpoint has to
    // round up to step two. A spare register index is written on the way.
    write_reg(cpf_pkg::REG_RAW_FINE, 16'd1000);
    write_reg(cpf_pkg::REG_RAW_COARSE, 16'hfc18);
    write_reg(cpf_pkg::REG_REVERSE, 16'd0);
    write_reg(cpf_pkg::REG_STEP_COUNT, 16'd2);
    write_reg(cpf_pkg::REG_ALPHA, 16'd32768);
    write_reg(REG_SPARE_FIRST, 16'hffff);
    cfg_valid <= 1'b0;
    send_reading(16'sd1000);
    send_reading(-16'sd1000);
    send_reading(16'sd0);
    send_reading(16'sd500);
    send_reading(16'sd2000);
    send_reading(-16'sd2000);
    wait_for_results();

    // Equal points after the filter has been seeded: state is held, the echo moves.
    write_reg(cpf_pkg::REG_RAW_COARSE, 16'd1000);
    cfg_valid <= 1'b0;
    send_reading(16'sd5);
    send_reading(-16'sd5);
    wait_for_results();
    settings_used = settings_used + 6;

    // Random part in three idling modes: sender seldom idle, receiver often busy, then
    // the other way round, then neither idles. Each segment starts from an idle block
    // with a fresh calibration, and one segment per mode includes the long hold-off.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          src_idle_pct = 27;
          sink_idle_pct <= 60;
        end
        1: begin
          src_idle_pct = 60;
          sink_idle_pct <= 27;
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct <= 0;
        end
      endcase
      for (int seg = 0; seg < SEGMENTS_PER_MODE; seg++) begin
        pick_settings();
        if (seg == HOLD_SEGMENT) hold_request <= 1'b1;
        n_items = $urandom_range(20, 40);
        repeat (n_items) send_reading(pick_reading(cur_fine, cur_coarse));
        wait_for_results();
      end
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d readings under %0d calibrations (%0d register writes).",
             readings_sent, settings_used, reg_writes);
    $display("%0d results compared, %0d of them with equal calibration points.",
             checked, error_results);
    if (fail_count == 0 && pending == 0) begin
      $display("calibrated_position_filter regression: pass");
    end else begin
      $display("calibrated_position_filter regression: fail");
    end
    $finish;
  end

endmodule
